### rtl/core/assert_macros.svh
// -----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the tag remapper RTL.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The expression must never be true at a rising clock edge outside reset.
`define ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

### rtl/core/lrtr_pkg.sv
// -----------------------------------------------------------------------------
// lrtr_pkg
// Types and constants shared by the local request tag remapper modules.
// -----------------------------------------------------------------------------
`default_nettype none

package lrtr_pkg;

  // Session table size. It must be a power of two, because the slot index
  // is taken from the low bits of the sequence number and of the counter.
  localparam int SLOTS  = 16;
  localparam int SLOT_W = $clog2(SLOTS);

  // Command queue between the classifier and the table engine.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [31:0] EXPIRY_RESET    = 32'd30000;
  localparam logic [15:0] OWN_ID_RESET    = 16'd1;
  localparam logic [15:0] SERVER_RESET    = 16'd0;

  typedef enum logic [1:0] {
    REG_SERVER_ID     = 2'd0,
    REG_OWN_ID        = 2'd1,
    REG_EXPIRY_MS     = 2'd2,
    REG_SHUTTING_DOWN = 2'd3
  } reg_idx_t;

  typedef enum logic {
    OP_REQUEST = 1'b0,
    OP_REPLY   = 1'b1
  } op_t;

  typedef struct packed {
    logic [15:0] server_id;
    logic [15:0] own_id;
    logic [31:0] expiry_ms;
    logic        shutting_down;
  } cfg_t;

  typedef struct packed {
    op_t               op;
    logic [SLOT_W-1:0] slot;
    logic [15:0]       sender;
    logic [15:0]       rsender;
    logic [15:0]       seq;
    logic [15:0]       tag;
    logic [31:0]       now;
    logic              alive;
  } cmd_t;

endpackage

`default_nettype wire

### rtl/core/lrtr_front.sv
// -----------------------------------------------------------------------------
// lrtr_front
// Accepts headers, drops broadcasts and everything while shut down, tells
// replies from requests and assigns the request tag.
// -----------------------------------------------------------------------------
`default_nettype none

module lrtr_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire lrtr_pkg::cfg_t    cfg,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [15:0]       sender_id,
  input  wire logic [15:0]       remote_sender_id,
  input  wire logic [15:0]       seq_num,
  input  wire logic              is_broadcast,
  input  wire logic [31:0]       now_ms,
  input  wire logic              slot_proxy_alive,
  input  wire logic              q_ready,
  output logic                   q_push,
  output lrtr_pkg::cmd_t         q_cmd
);

  logic [15:0] req_cnt_r;
  logic [15:0] req_cnt_nxt;
  logic        accept;
  logic        drop;
  logic        is_rsp;

  assign in_ready = q_ready;
  assign accept   = in_valid && q_ready;
  assign drop     = cfg.shutting_down || is_broadcast;
  assign is_rsp   = (sender_id == cfg.server_id) && (remote_sender_id == 16'd0);
  assign q_push   = accept && !drop;

  always_comb begin
    q_cmd.op      = is_rsp ? lrtr_pkg::OP_REPLY : lrtr_pkg::OP_REQUEST;
    q_cmd.slot    = is_rsp ? seq_num[lrtr_pkg::SLOT_W-1:0]
                           : req_cnt_r[lrtr_pkg::SLOT_W-1:0];
    q_cmd.sender  = sender_id;
    q_cmd.rsender = remote_sender_id;
    q_cmd.seq     = seq_num;
    q_cmd.tag     = req_cnt_r;
    q_cmd.now     = now_ms;
    q_cmd.alive   = slot_proxy_alive;
  end

  // The tag counter advances once per request, wrapping at 16 bits.
  always_comb begin
    req_cnt_nxt = req_cnt_r;
    if (q_push && !is_rsp) begin
      req_cnt_nxt = req_cnt_r + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_cnt_r <= 16'd0;
    end else begin
      req_cnt_r <= req_cnt_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/core/lrtr_queue.sv
// -----------------------------------------------------------------------------
// lrtr_queue
// Small command FIFO between the classifier and the table engine.
// -----------------------------------------------------------------------------
`default_nettype none

module lrtr_queue (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          push,
  input  wire lrtr_pkg::cmd_t                push_cmd,
  output logic                               push_ready,
  input  wire logic                          pop,
  output lrtr_pkg::cmd_t                     head,
  output logic                               head_valid,
  output logic [lrtr_pkg::QCNT_W-1:0]        level
);

  lrtr_pkg::cmd_t                  mem_r [lrtr_pkg::QDEPTH];
  logic [lrtr_pkg::QPTR_W-1:0]     wr_ptr_r;
  logic [lrtr_pkg::QPTR_W-1:0]     wr_ptr_nxt;
  logic [lrtr_pkg::QPTR_W-1:0]     rd_ptr_r;
  logic [lrtr_pkg::QPTR_W-1:0]     rd_ptr_nxt;
  logic [lrtr_pkg::QCNT_W-1:0]     count_r;
  logic [lrtr_pkg::QCNT_W-1:0]     count_nxt;

  assign push_ready = (count_r != lrtr_pkg::QCNT_W'(lrtr_pkg::QDEPTH));
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];
  assign level      = count_r;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/core/lrtr_back.sv
// -----------------------------------------------------------------------------
// lrtr_back
// Session table engine: stores requests, matches replies and drives the
// registered result item.
// -----------------------------------------------------------------------------
`default_nettype none

module lrtr_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire lrtr_pkg::cfg_t cfg,
  input  wire lrtr_pkg::cmd_t cmd,
  input  wire logic           cmd_valid,
  output logic                cmd_pop,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [15:0]         post_to,
  output logic [15:0]         target_id,
  output logic [15:0]         remote_sender_out,
  output logic [15:0]         seq_out,
  output logic                is_reply
);

  logic [15:0] proxy_r  [lrtr_pkg::SLOTS];
  logic [15:0] client_r [lrtr_pkg::SLOTS];
  logic [15:0] oseq_r   [lrtr_pkg::SLOTS];
  logic [31:0] stamp_r  [lrtr_pkg::SLOTS];

  logic        out_valid_r;
  logic        out_valid_nxt;
  logic [15:0] post_to_r;
  logic [15:0] target_r;
  logic [15:0] rsend_r;
  logic [15:0] seq_out_r;
  logic        is_reply_r;

  logic        is_req;
  logic        hit;
  logic [31:0] elapsed;
  logic        emit;

  assign cmd_pop = cmd_valid && (!out_valid_r || out_ready);
  assign is_req  = (cmd.op == lrtr_pkg::OP_REQUEST);
  assign hit     = !is_req && (proxy_r[cmd.slot] != 16'd0) && cmd.alive;
  assign elapsed = cmd.now - stamp_r[cmd.slot];
  assign emit    = is_req || (hit && (elapsed < cfg.expiry_ms));

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd_pop) begin
      out_valid_nxt = emit;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Only the proxy field marks a slot as taken, so it alone needs a reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < lrtr_pkg::SLOTS; i++) begin
        proxy_r[i] <= 16'd0;
      end
    end else if (cmd_pop && is_req) begin
      proxy_r[cmd.slot] <= cmd.sender;
    end else if (cmd_pop && hit) begin
      proxy_r[cmd.slot] <= 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop && is_req) begin
      client_r[cmd.slot] <= cmd.rsender;
      oseq_r[cmd.slot]   <= cmd.seq;
      stamp_r[cmd.slot]  <= cmd.now;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop && emit) begin
      if (is_req) begin
        post_to_r  <= cfg.server_id;
        target_r   <= cfg.server_id;
        rsend_r    <= cfg.own_id;
        seq_out_r  <= cmd.tag;
        is_reply_r <= 1'b0;
      end else begin
        post_to_r  <= proxy_r[cmd.slot];
        target_r   <= client_r[cmd.slot];
        rsend_r    <= 16'd0;
        seq_out_r  <= oseq_r[cmd.slot];
        is_reply_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign post_to           = post_to_r;
  assign target_id         = target_r;
  assign remote_sender_out = rsend_r;
  assign seq_out           = seq_out_r;
  assign is_reply          = is_reply_r;

endmodule

`default_nettype wire

### rtl/core/local_request_tag_remapper_core.sv
// -----------------------------------------------------------------------------
// local_request_tag_remapper_core
// Remaps sequence numbers of message headers between clients and one local
// server through a table of sessions with an age limit.
// -----------------------------------------------------------------------------
// Usage:
// Headers arrive as items on the in_ stream; each one that is not dropped
// yields at most one forwarded header on the out_ stream. A request takes
// the slot picked by a 16-bit tag counter and goes to the server carrying
// that tag. A reply from the server looks up the slot picked by its sequence
// number and, if the slot is live and young enough, goes back to the stored
// proxy with the original client and sequence number.
// The block takes one item per cycle while the queue has room: the
// classifier pushes into a four-entry command queue and the table engine
// retires one command per cycle while the output register is free or
// being taken, bounded by the single read and write of the session table in
// that engine. A synchronous reset frees every table slot, clears the tag
// counter, the queue and the output valid flag, and loads the register
// defaults. When the receiver holds out_tready low, the result stays in the
// output register, the engine stops, the queue fills and in_tready then
// drops. Registers on the APB port must be written by the user only while
// the block is idle; the block itself does not enforce this.
// -----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module local_request_tag_remapper_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input stream.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [15:0] sender_id, [31:16] remote_sender_id, [47:32] seq_num,
  // [79:48] now_ms, [80] slot_proxy_alive, [87:81] zero
  input  wire logic [87:0] in_tdata,
  // [0] is_broadcast
  input  wire logic        in_tuser,
  // Result stream.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [15:0] post_to, [31:16] target_id, [47:32] remote_sender_out,
  // [63:48] seq_out
  output logic [63:0]      out_tdata,
  // [0] is_reply
  output logic             out_tuser,
  // Configuration port.
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  lrtr_pkg::cfg_t                   cfg_r;
  lrtr_pkg::cfg_t                   cfg_nxt;
  logic                             cfg_wr;
  lrtr_pkg::reg_idx_t               reg_idx;

  logic                             q_push;
  logic                             q_ready;
  lrtr_pkg::cmd_t                   q_cmd;
  logic                             q_pop;
  logic                             q_valid;
  lrtr_pkg::cmd_t                   q_head;
  logic [lrtr_pkg::QCNT_W-1:0]      q_level;

  logic [15:0]                      post_to;
  logic [15:0]                      target_id;
  logic [15:0]                      remote_sender_out;
  logic [15:0]                      seq_out;
  logic                             is_reply;

  // APB register file; every access completes in its access cycle.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_idx    = lrtr_pkg::reg_idx_t'(cfg_paddr[3:2]);

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      case (reg_idx)
        lrtr_pkg::REG_SERVER_ID:     cfg_nxt.server_id     = cfg_pwdata[15:0];
        lrtr_pkg::REG_OWN_ID:        cfg_nxt.own_id        = cfg_pwdata[15:0];
        lrtr_pkg::REG_EXPIRY_MS:     cfg_nxt.expiry_ms     = cfg_pwdata;
        lrtr_pkg::REG_SHUTTING_DOWN: cfg_nxt.shutting_down = cfg_pwdata[0];
        default:                     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      lrtr_pkg::REG_SERVER_ID:     cfg_prdata = {16'd0, cfg_r.server_id};
      lrtr_pkg::REG_OWN_ID:        cfg_prdata = {16'd0, cfg_r.own_id};
      lrtr_pkg::REG_EXPIRY_MS:     cfg_prdata = cfg_r.expiry_ms;
      lrtr_pkg::REG_SHUTTING_DOWN: cfg_prdata = {31'd0, cfg_r.shutting_down};
      default:                     cfg_prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.server_id     <= lrtr_pkg::SERVER_RESET;
      cfg_r.own_id        <= lrtr_pkg::OWN_ID_RESET;
      cfg_r.expiry_ms     <= lrtr_pkg::EXPIRY_RESET;
      cfg_r.shutting_down <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front end: accepts and classifies items.
  lrtr_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .in_valid         (in_tvalid),
    .in_ready         (in_tready),
    .sender_id        (in_tdata[15:0]),
    .remote_sender_id (in_tdata[31:16]),
    .seq_num          (in_tdata[47:32]),
    .is_broadcast     (in_tuser),
    .now_ms           (in_tdata[79:48]),
    .slot_proxy_alive (in_tdata[80]),
    .q_ready          (q_ready),
    .q_push           (q_push),
    .q_cmd            (q_cmd)
  );

  // Command queue decouples the classifier from the table engine.
  lrtr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (q_cmd),
    .push_ready (q_ready),
    .pop        (q_pop),
    .head       (q_head),
    .head_valid (q_valid),
    .level      (q_level)
  );

  // Back end: session table and result register.
  lrtr_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .cmd               (q_head),
    .cmd_valid         (q_valid),
    .cmd_pop           (q_pop),
    .out_valid         (out_tvalid),
    .out_ready         (out_tready),
    .post_to           (post_to),
    .target_id         (target_id),
    .remote_sender_out (remote_sender_out),
    .seq_out           (seq_out),
    .is_reply          (is_reply)
  );

  assign out_tdata = {seq_out, remote_sender_out, target_id, post_to};
  assign out_tuser = is_reply;

  // A dropped item must never reach the queue.
  `ASSERT_NEVER(a_no_push_when_dropped, in_tvalid && in_tready && (cfg_r.shutting_down || in_tuser) && q_push, "dropped item entered the command queue")
  // The engine only retires commands that exist.
  `ASSERT_CLK(a_pop_needs_entry, q_pop |-> q_valid && (q_level != '0), "pop from an empty command queue")
  // A forwarded reply never carries a remote sender.
  `ASSERT_CLK(a_reply_rsend_zero, out_tvalid && out_tuser |-> out_tdata[47:32] == 16'd0, "reply carries a remote sender")
  // A forwarded request goes to the configured server.
  `ASSERT_CLK(a_request_to_server, out_tvalid && !out_tuser |-> out_tdata[15:0] == cfg_r.server_id, "request not posted to the server")

endmodule

`default_nettype wire

### tb/sv/local_request_tag_remapper_core_tb.sv
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// local_request_tag_remapper_core_tb
// Self-checking bench for the tag remapper core. Headers go in on the input
// stream, and a session table model in the bench predicts every forwarded
// header. Each output item is checked field by field against the oldest
// prediction. Directed cases come first: session paths, drop rules and age
// limits. Random traffic then runs under several register settings, and a
// burst of back-to-back requests with replies to them closes the run.
// -----------------------------------------------------------------------------

module local_request_tag_remapper_core_tb;

  // Header fields as they travel on the input stream.
  typedef struct packed {
    logic [15:0] sender;
    logic [15:0] rsender;
    logic [15:0] seq;
    logic        bcast;
    logic [31:0] now;
    logic        alive;
  } msg_hdr_t;

  // One forwarded header as the output stream carries it.
  typedef struct packed {
    logic [15:0]     post_to;
    logic [15:0]     target_id;
    logic [15:0]     rsend;
    logic [15:0]     seq;
    lrtr_pkg::op_t   kind;
  } fwd_hdr_t;

  // The settle time covers the pipeline and a queue of headers that are not
  // forwarded behind it. The watchdog limit lies far above the longest quiet
  // stretch of a correct run.
  localparam int SETTLE_CYCLES = 12;
  localparam int END_CYCLES    = 20;
  localparam int WATCHDOG_MAX  = 2000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [87:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;
  logic        out_tuser;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // Bench copy of the registers and of the session table.
  logic [15:0] reg_server   = lrtr_pkg::SERVER_RESET;
  logic [15:0] reg_own      = lrtr_pkg::OWN_ID_RESET;
  logic [31:0] reg_expiry   = lrtr_pkg::EXPIRY_RESET;
  logic        reg_shutdown = 1'b0;
  logic [15:0] sess_proxy  [lrtr_pkg::SLOTS];
  logic [15:0] sess_client [lrtr_pkg::SLOTS];
  logic [15:0] sess_seq    [lrtr_pkg::SLOTS];
  logic [31:0] sess_stamp  [lrtr_pkg::SLOTS];
  logic [15:0] next_tag = 16'd0;

  // Forwarded headers predicted but not yet seen on the output stream.
  fwd_hdr_t fwd_expected [$];

  int          errors      = 0;
  int          tx_idle_max = 10;
  int          rx_idle_max = 10;
  int          quiet_cycles = 0;
  logic [31:0] ms_clock    = 32'd0;

  local_request_tag_remapper_core u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Session table model. It returns 1 when the header is forwarded and
  // updates the table and the tag counter exactly as the block should.
  function automatic bit remap_header(input msg_hdr_t h, output fwd_hdr_t f);
    logic [lrtr_pkg::SLOT_W-1:0] idx;
    logic [31:0]                 age;
    bit                          fwd;
    f = '0;
    // Broadcasts and anything arriving during shutdown leave no trace.
    if (reg_shutdown || h.bcast) begin
      return 1'b0;
    end
    if (h.sender == reg_server && h.rsender == 16'd0) begin
      // A reply only acts on a live slot whose proxy is still reachable.
      idx = h.seq[lrtr_pkg::SLOT_W-1:0];
      if (sess_proxy[idx] == 16'd0 || !h.alive) begin
        return 1'b0;
      end
      // The age wraps at 32 bits; an old session is cleared but not sent.
      age = h.now - sess_stamp[idx];
      fwd = (age < reg_expiry);
      f.post_to   = sess_proxy[idx];
      f.target_id = sess_client[idx];
      f.rsend     = 16'd0;
      f.seq       = sess_seq[idx];
      f.kind      = lrtr_pkg::OP_REPLY;
      sess_proxy[idx]  = 16'd0;
      sess_client[idx] = 16'd0;
      sess_seq[idx]    = 16'd0;
      return fwd;
    end
    // Every other header is a request that takes the slot of the tag.
    idx = next_tag[lrtr_pkg::SLOT_W-1:0];
    sess_proxy[idx]  = h.sender;
    sess_client[idx] = h.rsender;
    sess_seq[idx]    = h.seq;
    sess_stamp[idx]  = h.now;
    f.post_to   = reg_server;
    f.target_id = reg_server;
    f.rsend     = reg_own;
    f.seq       = next_tag;
    f.kind      = lrtr_pkg::OP_REQUEST;
    next_tag = next_tag + 16'd1;
    return 1'b1;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] exp_val,
                                      input logic [31:0] act_val);
    if (act_val !== exp_val) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_val, act_val);
    end
  endfunction

  function automatic logic [31:0] reg_value(input lrtr_pkg::reg_idx_t r);
    case (r)
      lrtr_pkg::REG_SERVER_ID:     return {16'd0, reg_server};
      lrtr_pkg::REG_OWN_ID:        return {16'd0, reg_own};
      lrtr_pkg::REG_EXPIRY_MS:     return reg_expiry;
      default:                     return {31'd0, reg_shutdown};
    endcase
  endfunction

  function automatic msg_hdr_t mk_hdr(input logic [15:0] sender, input logic [15:0] rsender,
                                      input logic [15:0] seq, input logic bcast,
                                      input logic [31:0] now, input logic alive);
    msg_hdr_t h;
    h.sender  = sender;
    h.rsender = rsender;
    h.seq     = seq;
    h.bcast   = bcast;
    h.now     = now;
    h.alive   = alive;
    return h;
  endfunction

  // Output checker: every item on the output stream must match the oldest
  // prediction, field by field.
  always @(posedge clk) begin
    fwd_hdr_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (fwd_expected.size() == 0) begin
        errors++;
        $display("%0t: unexpected output item, expected none, actual %h / %b",
                 $time, out_tdata, out_tuser);
      end else begin
        want = fwd_expected.pop_front();
        check_field("post_to", {16'd0, want.post_to}, {16'd0, out_tdata[15:0]});
        check_field("target_id", {16'd0, want.target_id}, {16'd0, out_tdata[31:16]});
        check_field("remote_sender_out", {16'd0, want.rsend}, {16'd0, out_tdata[47:32]});
        check_field("seq_out", {16'd0, want.seq}, {16'd0, out_tdata[63:48]});
        check_field("is_reply", {31'd0, want.kind}, {31'd0, out_tuser});
      end
    end
  end

  // Receiver pacing: before each output item the receiver holds tready low
  // for a random number of cycles, then keeps it high until an item moves.
  initial begin : rx_pacer
    int stall;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      stall = $urandom_range(0, rx_idle_max);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
    end
  end

  // Watchdog: a run that moves nothing on any port for too long is hung.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_psel && cfg_penable && cfg_pready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_MAX) begin
        $display("%0t: watchdog expired with %0d items outstanding",
                 $time, fwd_expected.size());
        $display("local_request_tag_remapper_core_tb: FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Sends one header after a random gap and predicts its outcome at the
  // accepting edge. It is entered and left at a falling edge.
  task automatic send_header(input msg_hdr_t h);
    int       gap;
    fwd_hdr_t f;
    gap = $urandom_range(0, tx_idle_max);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  <= {7'd0, h.alive, h.now, h.seq, h.rsender, h.sender};
    in_tuser  <= h.bcast;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    if (remap_header(h, f)) begin
      fwd_expected = {fwd_expected, f};
    end
    @(negedge clk);
  endtask

  // One APB transfer: setup cycle, then access cycle. Left at a falling edge
  // after the port went quiet.
  task automatic apb_cycle(input bit wr, input lrtr_pkg::reg_idx_t r,
                           input logic [31:0] wdata, output logic [31:0] rdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= {r, 2'b00};
    cfg_pwdata  <= wdata;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
  endtask

  // Writes a register, updates the bench copy and reads the value back.
  task automatic set_reg(input lrtr_pkg::reg_idx_t r, input logic [31:0] value);
    logic [31:0] rd;
    apb_cycle(1'b1, r, value, rd);
    case (r)
      lrtr_pkg::REG_SERVER_ID:     reg_server   = value[15:0];
      lrtr_pkg::REG_OWN_ID:        reg_own      = value[15:0];
      lrtr_pkg::REG_EXPIRY_MS:     reg_expiry   = value;
      default:                     reg_shutdown = value[0];
    endcase
    apb_cycle(1'b0, r, 32'd0, rd);
    check_field($sformatf("register %s", r.name()), reg_value(r), rd);
  endtask

  // Lets the block run dry before a register write: all predicted items out,
  // then enough cycles for headers still queued inside it.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (fwd_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // One random header. Most are requests or replies to recent tags, so that
  // sessions are found, aged out, kept for dead proxies or overwritten; the
  // rest are broadcasts and headers with every field random.
  task automatic send_mixed(input int count, input logic [31:0] step_max);
    int          kind;
    int          pick;
    logic [15:0] tag;
    logic [15:0] rnd;
    msg_hdr_t    h;
    repeat (count) begin
      if (step_max == 32'hFFFF_FFFF) begin
        ms_clock = ms_clock + $urandom;
      end else begin
        ms_clock = ms_clock + $urandom_range(0, step_max);
      end
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        pick = $urandom_range(0, 9);
        h = mk_hdr(16'($urandom), 16'($urandom), 16'($urandom), 1'b0, ms_clock,
                   1'($urandom));
        if (pick == 0) begin
          // A request from sender zero leaves its slot looking free.
          h.sender = 16'd0;
        end else if (pick == 1) begin
          // The server posting with a remote sender is still a request.
          h.sender  = reg_server;
          h.rsender = 16'($urandom_range(1, 65535));
        end
      end else if (kind < 80) begin
        tag = next_tag - 16'd1 - 16'($urandom_range(0, 24));
        rnd = 16'($urandom);
        rnd[lrtr_pkg::SLOT_W-1:0] = tag[lrtr_pkg::SLOT_W-1:0];
        h = mk_hdr(reg_server, 16'd0, rnd, 1'b0, ms_clock, ($urandom_range(0, 99) < 85));
      end else if (kind < 90) begin
        h = mk_hdr(16'($urandom), 16'($urandom), 16'($urandom), 1'b1, $urandom,
                   1'($urandom));
      end else begin
        h = mk_hdr(16'($urandom), 16'($urandom), 16'($urandom), 1'($urandom), $urandom,
                   1'($urandom));
      end
      send_header(h);
    end
  endtask

  // Reset values must read back before anything is written.
  task automatic test_register_defaults();
    logic [31:0]        rd;
    lrtr_pkg::reg_idx_t r;
    r = lrtr_pkg::REG_SERVER_ID;
    repeat (4) begin
      apb_cycle(1'b0, r, 32'd0, rd);
      check_field($sformatf("reset value of %s", r.name()), reg_value(r), rd);
      r = r.next();
    end
  endtask

  // Request and reply paths through single slots, one case at a time.
  task automatic test_session_paths();
    set_reg(lrtr_pkg::REG_SERVER_ID, 32'h0000_1234);
    set_reg(lrtr_pkg::REG_OWN_ID, 32'h0000_FFFF);
    set_reg(lrtr_pkg::REG_EXPIRY_MS, 32'd500);
    // Reply into a free slot: nothing goes out.
    send_header(mk_hdr(16'h1234, 16'h0000, 16'h0000, 1'b0, 32'h0000_0000, 1'b1));
    // All-ones request, answered across the 32-bit wrap of the time.
    send_header(mk_hdr(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 32'hFFFF_FFF0, 1'b1));
    send_header(mk_hdr(16'h1234, 16'h0000, 16'h0000, 1'b0, 32'h0000_0010, 1'b1));
    // The slot was cleared, so a second reply finds it free.
    send_header(mk_hdr(16'h1234, 16'h0000, 16'hFFF0, 1'b0, 32'h0000_0011, 1'b1));
    // Dead proxy: the slot is kept, and a later reply one below the age
    // limit still goes out.
    send_header(mk_hdr(16'h0001, 16'h0000, 16'h0000, 1'b0, 32'd100, 1'b0));
    send_header(mk_hdr(16'h1234, 16'h0000, 16'h0001, 1'b0, 32'd101, 1'b0));
    send_header(mk_hdr(16'h1234, 16'h0000, 16'h8001, 1'b0, 32'd599, 1'b1));
    // Exactly at the age limit the reply is dropped and the slot cleared.
    send_header(mk_hdr(16'h00AA, 16'h5555, 16'hAAAA, 1'b0, 32'd1000, 1'b1));
    send_header(mk_hdr(16'h1234, 16'h0000, 16'h0002, 1'b0, 32'd1500, 1'b1));
    send_header(mk_hdr(16'h1234, 16'h0000, 16'h0002, 1'b0, 32'd1501, 1'b1));
    // Sender zero is stored as given, so its slot reads as free.
    send_header(mk_hdr(16'h0000, 16'h7777, 16'h1111, 1'b0, 32'd2000, 1'b1));
    send_header(mk_hdr(16'h1234, 16'h0000, 16'h0003, 1'b0, 32'd2001, 1'b1));
    // The server with a remote sender is a request like any other.
    send_header(mk_hdr(16'h1234, 16'h0001, 16'h4321, 1'b0, 32'd3000, 1'b1));
    send_header(mk_hdr(16'h1234, 16'h0000, 16'h0004, 1'b0, 32'd3001, 1'b1));
    wait_idle();
  endtask

  // Broadcasts and shutdown drop headers without touching the table.
  task automatic test_drop_rules();
    send_header(mk_hdr(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 32'hFFFF_FFFF, 1'b1));
    send_header(mk_hdr(16'h0202, 16'h0303, 16'h0404, 1'b0, 32'd4000, 1'b1));
    send_header(mk_hdr(16'h1234, 16'h0000, 16'h0005, 1'b1, 32'd4001, 1'b1));
    wait_idle();
    set_reg(lrtr_pkg::REG_SHUTTING_DOWN, 32'd1);
    send_header(mk_hdr(16'h0606, 16'h0707, 16'h0808, 1'b0, 32'd4001, 1'b1));
    send_header(mk_hdr(16'h1234, 16'h0000, 16'h0005, 1'b0, 32'd4001, 1'b1));
    wait_idle();
    set_reg(lrtr_pkg::REG_SHUTTING_DOWN, 32'd0);
    // The session opened before shutdown is still there.
    send_header(mk_hdr(16'h1234, 16'h0000, 16'h0005, 1'b0, 32'd4002, 1'b1));
    wait_idle();
  endtask

  // Age limit extremes: zero drops every reply, all ones keeps nearly all.
  task automatic test_expiry_edges();
    set_reg(lrtr_pkg::REG_EXPIRY_MS, 32'd0);
    send_header(mk_hdr(16'h0A0A, 16'h0B0B, 16'h0C0C, 1'b0, 32'd5000, 1'b1));
    send_header(mk_hdr(16'h1234, 16'h0000, 16'h0006, 1'b0, 32'd5000, 1'b1));
    send_header(mk_hdr(16'h1234, 16'h0000, 16'h0006, 1'b0, 32'd5000, 1'b1));
    wait_idle();
    set_reg(lrtr_pkg::REG_EXPIRY_MS, 32'hFFFF_FFFF);
    send_header(mk_hdr(16'h0D0D, 16'h0E0E, 16'h0F0F, 1'b0, 32'd0, 1'b1));
    send_header(mk_hdr(16'h1234, 16'h0000, 16'h0007, 1'b0, 32'hFFFF_FFFE, 1'b1));
    wait_idle();
  endtask

  // One phase of random traffic under one register setting.
  task automatic run_phase(input logic [15:0] server, input logic [15:0] own,
                           input logic [31:0] expiry, input logic shut,
                           input logic [31:0] step_max, input int idle, input int count);
    wait_idle();
    set_reg(lrtr_pkg::REG_SERVER_ID, {16'd0, server});
    set_reg(lrtr_pkg::REG_OWN_ID, {16'd0, own});
    set_reg(lrtr_pkg::REG_EXPIRY_MS, expiry);
    set_reg(lrtr_pkg::REG_SHUTTING_DOWN, {31'd0, shut});
    tx_idle_max = idle;
    rx_idle_max = idle;
    send_mixed(count, step_max);
    tx_idle_max = 10;
    rx_idle_max = 10;
  endtask

  task automatic test_random_traffic();
    run_phase(16'($urandom_range(1, 65535)), 16'($urandom), 32'd1000, 1'b0, 32'd150,
              10, 280);
    run_phase(16'h0000, 16'h0000, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF, 10, 280);
    // A stretch with no idling on either side and a one millisecond limit.
    run_phase(16'hFFFF, 16'hFFFF, 32'd1, 1'b0, 32'd1, 0, 230);
    // Start just below the time wrap with a random limit.
    ms_clock = 32'hFFFF_F000;
    run_phase(16'($urandom), 16'($urandom), $urandom, 1'b0, 32'd4000, 10, 280);
    run_phase(16'($urandom), 16'($urandom), 32'd400, 1'b1, 32'd50, 10, 50);
    run_phase(16'($urandom_range(1, 65535)), 16'($urandom), 32'd400, 1'b0, 32'd60,
              10, 280);
  endtask

  // A burst of back-to-back requests with the receiver always ready, then
  // replies mixed with new traffic against the freshly filled table.
  task automatic test_tag_counter_wrap();
    tx_idle_max = 0;
    rx_idle_max = 0;
    repeat (40) begin
      ms_clock = ms_clock + 32'd1;
      send_header(mk_hdr(16'($urandom_range(1, 65535)), 16'($urandom), 16'($urandom),
                         1'b0, ms_clock, 1'b1));
    end
    tx_idle_max = 10;
    rx_idle_max = 10;
    send_mixed(40, 32'd20);
  endtask

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = 1'b0;
    out_tready  = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    for (int k = 0; k < lrtr_pkg::SLOTS; k++) begin
      sess_proxy[k]  = 16'd0;
      sess_client[k] = 16'd0;
      sess_seq[k]    = 16'd0;
      sess_stamp[k]  = 32'd0;
    end
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_register_defaults();
    test_session_paths();
    test_drop_rules();
    test_expiry_edges();
    test_random_traffic();
    test_tag_counter_wrap();

    // Drain: every prediction must come out, and nothing more may follow.
    in_tvalid <= 1'b0;
    while (fwd_expected.size() != 0) @(posedge clk);
    repeat (END_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("local_request_tag_remapper_core_tb: PASS");
    end else begin
      $display("local_request_tag_remapper_core_tb: FAIL");
    end
    $finish;
  end

endmodule
